@@ design/assert_macros.svh @@
// assertion macros shared by the scorer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SBDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled while reset is held
`define SBDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ design/sbdp_pkg.sv @@
// types and constants shared by the sparse block dot product scorer
package sbdp_pkg;

    // command codes of an input word
    localparam logic [2:0] CMD_LOAD_WEIGHT = 3'd0;
    localparam logic [2:0] CMD_LOAD_BIAS   = 3'd1;
    localparam logic [2:0] CMD_LOAD_BASE   = 3'd2;
    localparam logic [2:0] CMD_BLOCK_START = 3'd3;
    localparam logic [2:0] CMD_FEATURE     = 3'd4;

    localparam int ADDR_W = 12;
    localparam int DS_W   = 6;   // widest reduced dataset index
    localparam int BLK_W  = 6;
    localparam int ROW_W  = 22;  // widest bias row base
    localparam int SUM_W  = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 8;
    localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

    typedef enum logic [2:0] {
        OP_LD_WEIGHT = 3'd0,
        OP_LD_BIAS   = 3'd1,
        OP_LD_BASE   = 3'd2,
        OP_START     = 3'd3,
        OP_FEATURE   = 3'd4
    } t_op;

    // classified word handed from the front to the back
    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  addr;
        logic [ROW_W-1:0]   row;
        logic [DS_W-1:0]    ds;
        logic [BLK_W-1:0]   block;
        logic               in_range;
        logic [31:0]        value;
        logic               last;
    } t_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] plain;
        logic signed [SUM_W-1:0] biased;
        logic [1:0]              ds;
    } t_result;

    function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W+1:0] v);
        logic signed [SUM_W-1:0] r;
        if (!v[SUM_W+1] && (v[SUM_W:SUM_W-1] != 2'b00)) begin
            r = SUM_MAX;
        end else if (v[SUM_W+1] && (v[SUM_W:SUM_W-1] != 2'b11)) begin
            r = SUM_MIN;
        end else begin
            r = v[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/sparse_block_dot_product_scorer.sv @@
// top level of the sparse block dot product scorer
// path: a last feature word passes these steps before its result enters the result queue
//   (2 front stages, queue, store read, multiply, add, accumulate)
// throughput: one word per cycle while full is low; last features wait only while the
//   8-entry result queue and the in-flight results fill it
// reset: synchronous active low; clears pointer, sums, dataset and queues, not the stores
module sparse_block_dot_product_scorer #(
    parameter int WEIGHT_WORDS = 4096,
    parameter int MAX_BLOCKS   = 64,
    parameter int DATASETS     = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input word channel
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_command,
    input  logic [1:0]         i_dataset,
    input  logic [5:0]         i_block,
    input  logic [11:0]        i_address,
    input  logic signed [31:0] i_value,
    input  logic               i_last,
    // result word channel
    output logic               empty,
    input  logic               pop,
    output logic signed [47:0] o_plain_score,
    output logic signed [47:0] o_biased_score,
    output logic [1:0]         o_example_dataset
);
    import sbdp_pkg::*;

    // front to back queue
    logic              q_push;
    t_item             q_in;
    t_item             q_out;
    logic              q_pop;
    logic [QCNT_W-1:0] q_count;

    // back to result queue
    logic              res_push;
    t_result           res_in;
    t_result           res_out;
    logic [OCNT_W-1:0] res_count;

    // front part: classifies words, drops no-ops, reduces indexes
    sbdp_front #(
        .WEIGHT_WORDS (WEIGHT_WORDS),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .DATASETS     (DATASETS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_command     (i_command),
        .i_dataset     (i_dataset),
        .i_block       (i_block),
        .i_address     (i_address),
        .i_value       (i_value),
        .i_last        (i_last),
        .i_queue_count (q_count),
        .o_queue_push  (q_push),
        .o_queue_item  (q_in)
    );

    // short queue lets the front and back stall independently
    sbdp_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_count (q_count)
    );

    // back part: stores, multipliers and saturating accumulators
    sbdp_back #(
        .WEIGHT_WORDS (WEIGHT_WORDS),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .DATASETS     (DATASETS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_count != '0),
        .i_item       (q_out),
        .o_item_pop   (q_pop),
        .i_out_count  (res_count),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    // result queue decouples the consumer from the pipeline
    sbdp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop && !empty),
        .o_data  (res_out),
        .o_count (res_count)
    );

    // oldest result word sits on the ports while the queue holds one
    assign empty             = res_count == '0;
    assign o_plain_score     = res_out.plain;
    assign o_biased_score    = res_out.biased;
    assign o_example_dataset = res_out.ds;

endmodule

@@ design/sbdp_fifo.sv @@
// small register queue with fill count, used between the pipeline parts
`include "assert_macros.svh"
module sbdp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

    `SBDP_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop, int'(r_count) < DEPTH)
    `SBDP_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

@@ design/sbdp_front.sv @@
// front part: accepts words, drops no-ops, reduces address and dataset, feeds the queue
`include "assert_macros.svh"
module sbdp_front #(
    parameter int WEIGHT_WORDS = 4096,
    parameter int MAX_BLOCKS   = 64,
    parameter int DATASETS     = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [2:0]                  i_command,
    input  logic [1:0]                  i_dataset,
    input  logic [5:0]                  i_block,
    input  logic [11:0]                 i_address,
    input  logic [31:0]                 i_value,
    input  logic                        i_last,
    input  logic [sbdp_pkg::QCNT_W-1:0] i_queue_count,
    output logic                        o_queue_push,
    output sbdp_pkg::t_item             o_queue_item
);
    import sbdp_pkg::*;

    logic              accept;
    logic              keep;
    t_op               op;
    logic              block_ok;
    logic              bias_ok;
    logic [DS_W-1:0]   ds_mod;
    logic [ADDR_W-1:0] addr_mod;
    logic [2:0]        inflight;

    logic  r_f1_valid;
    t_item r_f1_item;
    logic  r_f2_valid;
    t_item r_f2_item;
    t_item n_f2_item;

    // words that change nothing stop here
    assign block_ok = int'(i_block) < MAX_BLOCKS;
    assign bias_ok  = int'(i_dataset) < DATASETS;

    always_comb begin
        keep = 1'b0;
        op   = OP_FEATURE;
        unique case (i_command)
            CMD_LOAD_WEIGHT: begin
                keep = 1'b1;
                op   = OP_LD_WEIGHT;
            end
            CMD_LOAD_BIAS: begin
                keep = bias_ok;
                op   = OP_LD_BIAS;
            end
            CMD_LOAD_BASE: begin
                keep = block_ok;
                op   = OP_LD_BASE;
            end
            CMD_BLOCK_START: begin
                keep = 1'b1;
                op   = OP_START;
            end
            CMD_FEATURE: begin
                keep = 1'b1;
                op   = OP_FEATURE;
            end
            default: begin
                keep = 1'b0;
                op   = OP_FEATURE;
            end
        endcase
    end

    // dataset modulo the dataset count, at most three subtractions
    always_comb begin
        ds_mod = DS_W'(i_dataset);
        for (int k = 0; k < 3; k++) begin
            if (int'(ds_mod) >= DATASETS) begin
                ds_mod = ds_mod - DS_W'(DATASETS);
            end
        end
    end

    assign inflight = 3'(r_f1_valid) + 3'(r_f2_valid);
    assign o_full   = (int'(i_queue_count) + int'(inflight)) >= QUEUE_DEPTH;
    assign accept   = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        r_f1_item.op       <= op;
        r_f1_item.addr     <= i_address;
        r_f1_item.row      <= '0;
        r_f1_item.ds       <= ds_mod;
        r_f1_item.block    <= i_block;
        r_f1_item.in_range <= block_ok;
        r_f1_item.value    <= i_value;
        r_f1_item.last     <= i_last;
    end

    // address modulo the weight space
    if (WEIGHT_WORDS < 4096) begin : g_reduce
        // reciprocal with 24 fraction bits is exact for 12-bit addresses when WEIGHT_WORDS is at least 8
        localparam int unsigned RECIP = (32'd1 << 24) / WEIGHT_WORDS + 1;
        logic [32:0] r_prod;
        logic [8:0]  quot;

        always_ff @(posedge i_clk) begin
            r_prod <= 33'(i_address) * 33'(RECIP);
        end

        assign quot     = r_prod[32:24];
        assign addr_mod = ADDR_W'(24'(r_f1_item.addr) - 24'(quot) * 24'(WEIGHT_WORDS));
    end else begin : g_pass
        assign addr_mod = r_f1_item.addr;
    end

    // second stage word: reduced address and bias row base
    always_comb begin
        n_f2_item      = r_f1_item;
        n_f2_item.addr = addr_mod;
        n_f2_item.row  = ROW_W'(r_f1_item.ds * WEIGHT_WORDS);
    end

    always_ff @(posedge i_clk) begin
        r_f2_item <= n_f2_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept && keep;
            r_f2_valid <= r_f1_valid;
        end
    end

    assign o_queue_push = r_f2_valid;
    assign o_queue_item = r_f2_item;

    `SBDP_ASSERT_NOW(a_queue_credit, i_clk, i_rst_n, 1'b1,
        (int'(i_queue_count) + int'(inflight)) <= QUEUE_DEPTH)

endmodule

@@ design/sbdp_back.sv @@
// back part: store access, multiply and saturating accumulate
`include "assert_macros.svh"
module sbdp_back #(
    parameter int WEIGHT_WORDS = 4096,
    parameter int MAX_BLOCKS   = 64,
    parameter int DATASETS     = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  sbdp_pkg::t_item             i_item,
    output logic                        o_item_pop,
    input  logic [sbdp_pkg::OCNT_W-1:0] i_out_count,
    output logic                        o_res_push,
    output sbdp_pkg::t_result           o_res
);
    import sbdp_pkg::*;

    localparam int PTR_W = (WEIGHT_WORDS > 1) ? $clog2(WEIGHT_WORDS) : 1;
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BIAS_WORDS = DATASETS * WEIGHT_WORDS;
    localparam int BA_W  = (BIAS_WORDS > 1) ? $clog2(BIAS_WORDS) : 1;

    logic signed [31:0] r_weight_mem [WEIGHT_WORDS];
    logic signed [31:0] r_bias_mem [BIAS_WORDS];
    logic [PTR_W-1:0]   r_base_mem [MAX_BLOCKS];

    logic signed [31:0] r_weight_q;
    logic signed [31:0] r_bias_q;
    logic [PTR_W-1:0]   r_base_q;

    logic [PTR_W-1:0]  r_fp;
    logic              r_start_pending;
    logic              r_start_inrange;
    logic [DS_W-1:0]   r_ds;
    logic [ROW_W-1:0]  r_bias_base;

    logic               r_s1_valid;
    logic               r_s1_last;
    logic [DS_W-1:0]    r_s1_ds;
    logic signed [15:0] r_s1_feat;

    logic                    r_s2_valid;
    logic                    r_s2_last;
    logic [DS_W-1:0]         r_s2_ds;
    logic signed [SUM_W-1:0] r_s2_pw;
    logic signed [SUM_W-1:0] r_s2_pb;

    logic                    r_s3_valid;
    logic                    r_s3_last;
    logic [DS_W-1:0]         r_s3_ds;
    logic signed [SUM_W-1:0] r_s3_plain;
    logic signed [SUM_W:0]   r_s3_biased;

    logic signed [SUM_W-1:0] r_plain_sum;
    logic signed [SUM_W-1:0] r_biased_sum;

    logic                    issue;
    logic                    credit_ok;
    logic [1:0]              lasts_inflight;
    logic [PTR_W-1:0]        cur_fp;
    logic [PTR_W-1:0]        n_fp;
    logic [BA_W-1:0]         bias_rd_addr;
    logic [BA_W-1:0]         bias_wr_addr;
    logic signed [SUM_W-1:0] n_pw;
    logic signed [SUM_W-1:0] n_pb;
    logic signed [SUM_W+1:0] plain_acc;
    logic signed [SUM_W+1:0] biased_acc;
    logic signed [SUM_W-1:0] plain_sat;
    logic signed [SUM_W-1:0] biased_sat;
    logic                    is_feat;

    // a last feature only goes once its result has a seat in the output queue
    assign lasts_inflight = 2'(r_s1_valid && r_s1_last) + 2'(r_s2_valid && r_s2_last)
                          + 2'(r_s3_valid && r_s3_last);
    assign credit_ok  = (int'(i_out_count) + int'(lasts_inflight)) < OUT_DEPTH;
    assign is_feat    = i_item.op == OP_FEATURE;
    assign issue      = i_item_valid && !(is_feat && i_item.last && !credit_ok);
    assign o_item_pop = issue;

    // pointer right after a block start comes from the base table read, or is zero for an out-of-range block
    always_comb begin
        if (r_start_pending) begin
            cur_fp = r_start_inrange ? r_base_q : '0;
        end else begin
            cur_fp = r_fp;
        end
        if (issue && is_feat) begin
            n_fp = (int'(cur_fp) == WEIGHT_WORDS - 1) ? '0 : cur_fp + 1'b1;
        end else begin
            n_fp = cur_fp;
        end
    end

    assign bias_rd_addr = BA_W'(r_bias_base + ROW_W'(cur_fp));
    assign bias_wr_addr = BA_W'(i_item.row + ROW_W'(i_item.addr));

    always_ff @(posedge i_clk) begin
        if (issue && (i_item.op == OP_LD_WEIGHT)) begin
            r_weight_mem[PTR_W'(i_item.addr)] <= i_item.value;
        end
        if (issue && is_feat) begin
            r_weight_q <= r_weight_mem[cur_fp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && (i_item.op == OP_LD_BIAS)) begin
            r_bias_mem[bias_wr_addr] <= i_item.value;
        end
        if (issue && is_feat) begin
            r_bias_q <= r_bias_mem[bias_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && (i_item.op == OP_LD_BASE)) begin
            r_base_mem[IDX_W'(i_item.block)] <= PTR_W'(i_item.addr);
        end
        if (issue && (i_item.op == OP_START) && i_item.in_range) begin
            r_base_q <= r_base_mem[IDX_W'(i_item.block)];
        end
    end

    assign n_pw = r_weight_q * r_s1_feat;
    assign n_pb = r_bias_q * r_s1_feat;

    assign plain_acc  = (SUM_W+2)'(r_plain_sum) + (SUM_W+2)'(r_s3_plain);
    assign biased_acc = (SUM_W+2)'(r_biased_sum) + (SUM_W+2)'(r_s3_biased);
    assign plain_sat  = sat48(plain_acc);
    assign biased_sat = sat48(biased_acc);

    // payload stages
    always_ff @(posedge i_clk) begin
        if (issue && (i_item.op == OP_START)) begin
            r_start_inrange <= i_item.in_range;
        end
        r_s1_last   <= i_item.last;
        r_s1_ds     <= r_ds;
        r_s1_feat   <= signed'(i_item.value[15:0]);
        r_s2_last   <= r_s1_last;
        r_s2_ds     <= r_s1_ds;
        r_s2_pw     <= n_pw;
        r_s2_pb     <= n_pb;
        r_s3_last   <= r_s2_last;
        r_s3_ds     <= r_s2_ds;
        r_s3_plain  <= r_s2_pw;
        r_s3_biased <= (SUM_W+1)'(r_s2_pw) + (SUM_W+1)'(r_s2_pb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp            <= '0;
            r_start_pending <= 1'b0;
            r_ds            <= '0;
            r_bias_base     <= '0;
            r_s1_valid      <= 1'b0;
            r_s2_valid      <= 1'b0;
            r_s3_valid      <= 1'b0;
            r_plain_sum     <= '0;
            r_biased_sum    <= '0;
        end else begin
            r_fp            <= n_fp;
            r_start_pending <= issue && (i_item.op == OP_START);
            if (issue && (i_item.op == OP_START)) begin
                r_ds        <= i_item.ds;
                r_bias_base <= i_item.row;
            end
            r_s1_valid <= issue && is_feat;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (r_s3_valid) begin
                if (r_s3_last) begin
                    r_plain_sum  <= '0;
                    r_biased_sum <= '0;
                end else begin
                    r_plain_sum  <= plain_sat;
                    r_biased_sum <= biased_sat;
                end
            end
        end
    end

    assign o_res_push    = r_s3_valid && r_s3_last;
    assign o_res.plain   = plain_sat;
    assign o_res.biased  = biased_sat;
    assign o_res.ds      = r_s3_ds[1:0];

    `SBDP_ASSERT_NEXT(a_sums_clear, i_clk, i_rst_n, r_s3_valid && r_s3_last,
        (r_plain_sum == '0) && (r_biased_sum == '0))

endmodule
